// File: sv/assert_macros.svh
// Assertion helpers for the RTL files; included by the engine.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS
// Same-cycle implication, checked on every rising edge out of reset.
`define CAHC_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication, checked on every rising edge out of reset.
`define CAHC_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define CAHC_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define CAHC_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

// File: sv/cahc_pkg.sv
package cahc_pkg;

  // Table geometry; TABLE_DEPTH must be a power of two
  localparam int unsigned TABLE_DEPTH = 1024;
  localparam int unsigned PROBE_LIMIT = 16;
  localparam int unsigned IDX_W       = $clog2(TABLE_DEPTH);
  localparam int unsigned PRB_W       = $clog2(PROBE_LIMIT + 1);
  localparam int unsigned SLOT_W      = 10;
  localparam int unsigned NUM_REGS    = 2;
  localparam int unsigned CFG_AW      = $clog2(NUM_REGS * 4);

  // Hash multipliers and saturation limit
  localparam logic [31:0] HASH_K1 = 32'h9e37_79b1;
  localparam logic [31:0] HASH_K2 = 32'h85eb_ca6b;
  localparam logic [31:0] CNT_MAX = 32'hffff_ffff;

  typedef logic [IDX_W-1:0] idx_t;

  typedef enum logic [2:0] {
    ST_IGNORED     = 3'd0,
    ST_NEW         = 3'd1,
    ST_INCREMENTED = 3'd2,
    ST_SATURATED   = 3'd3,
    ST_DROPPED     = 3'd4,
    ST_UNMAPPED    = 3'd5
  } status_t;

  typedef enum logic {
    REG_ENABLED   = 1'b0,
    REG_DRAIN_REQ = 1'b1
  } reg_idx_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_HASH1,
    S_HASH2,
    S_READ,
    S_CHECK,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic enabled;
    logic drain_requested;
  } cfg_t;

  // One table slot; a zero caller marks an empty slot
  typedef struct packed {
    logic [31:0] caller;
    logic [31:0] callee;
    logic [31:0] tally;
  } entry_t;

  typedef struct packed {
    logic   wr_en;
    idx_t   addr;
    entry_t wr_data;
  } tbl_req_t;

endpackage

// File: sv/cahc_if.sv
interface arc_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] caller_return_pc;
  logic [31:0] callee_return_pc;

  modport source (output valid, output caller_return_pc, output callee_return_pc,
                  input ready);
  modport sink (input valid, input caller_return_pc, input callee_return_pc,
                output ready);
endinterface

interface arc_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [9:0]  slot_index;
  logic [31:0] arc_count;
  logic        drain_ready;
  logic [31:0] dropped_total;
  logic [31:0] saturated_total;
  logic [31:0] unmapped_total;

  modport source (output valid, output status, output slot_index, output arc_count,
                  output drain_ready, output dropped_total, output saturated_total,
                  output unmapped_total, input ready);
  modport sink (input valid, input status, input slot_index, input arc_count,
                input drain_ready, input dropped_total, input saturated_total,
                input unmapped_total, output ready);
endinterface

// File: sv/cahc_cfg.sv
module cahc_cfg (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [cahc_pkg::CFG_AW-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  output cahc_pkg::cfg_t              cfg
);
  import cahc_pkg::*;

  cfg_t     cfg_r;
  cfg_t     cfg_nxt;
  reg_idx_t reg_idx;
  logic     wr_fire;

  assign pready  = 1'b1;
  assign reg_idx = reg_idx_t'(paddr[CFG_AW-1:2]);
  assign wr_fire = psel && penable && pwrite && pready;

  // Decode the write word; keep bit 0 only
  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_fire) begin
      case (reg_idx)
        REG_ENABLED:   cfg_nxt.enabled         = pwdata[0];
        REG_DRAIN_REQ: cfg_nxt.drain_requested = pwdata[0];
        default:       cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Read back the addressed register
  always_comb begin
    case (reg_idx)
      REG_ENABLED:   prdata = {31'd0, cfg_r.enabled};
      REG_DRAIN_REQ: prdata = {31'd0, cfg_r.drain_requested};
      default:       prdata = '0;
    endcase
  end

  assign cfg = cfg_r;

endmodule

// File: sv/cahc_table.sv
module cahc_table (
  input  logic               clk,
  input  cahc_pkg::tbl_req_t req,
  output cahc_pkg::entry_t   rd_data
);
  import cahc_pkg::*;

  entry_t mem [TABLE_DEPTH];
  entry_t rd_data_r;

  // Single port: write when asked, otherwise read into the output register
  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.addr] <= req.wr_data;
    end else begin
      rd_data_r <= mem[req.addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// File: sv/cahc_engine.sv
`include "assert_macros.svh"

module cahc_engine (
  input  logic               clk,
  input  logic               rst_n,
  input  cahc_pkg::cfg_t     cfg,
  arc_in_if.sink             in_arc,
  arc_out_if.source          out_arc,
  output cahc_pkg::tbl_req_t tbl_req,
  input  cahc_pkg::entry_t   tbl_rd
);
  import cahc_pkg::*;

  state_t            state_r, state_nxt;
  idx_t              clr_r, clr_nxt;
  logic [31:0]       caller_r, caller_nxt;
  logic [31:0]       callee_r, callee_nxt;
  logic [31:0]       prod_r, prod_nxt;
  idx_t              idx_r, idx_nxt;
  logic [PRB_W-1:0]  probe_r, probe_nxt;
  status_t           st_r, st_nxt;
  idx_t              slot_r, slot_nxt;
  logic [31:0]       cnt_r, cnt_nxt;
  logic [31:0]       drop_r, drop_nxt;
  logic [31:0]       sat_r, sat_nxt;
  logic [31:0]       unm_r, unm_nxt;

  logic              out_valid_r, out_valid_nxt;
  status_t           out_st_r;
  logic [SLOT_W-1:0] out_slot_r;
  logic [31:0]       out_cnt_r;
  logic              out_drain_r;
  logic [31:0]       out_drop_r;
  logic [31:0]       out_sat_r;
  logic [31:0]       out_unm_r;

  logic              in_fire;
  logic              out_load;
  logic [31:0]       mul_a, mul_b, mul_lo;
  logic [31:0]       hash_mix, hash_fold;
  logic              slot_empty, slot_match;

  assign in_fire = in_arc.valid && in_arc.ready;

  // Shared multiplier: caller term, then callee term
  always_comb begin
    case (state_r)
      S_HASH2: begin
        mul_a = {1'b0, callee_r[31:1]};
        mul_b = HASH_K2;
      end
      default: begin
        mul_a = {1'b0, caller_r[31:1]};
        mul_b = HASH_K1;
      end
    endcase
  end
  assign mul_lo    = mul_a * mul_b;
  assign hash_mix  = prod_r ^ mul_lo;
  assign hash_fold = hash_mix ^ {16'd0, hash_mix[31:16]};

  assign slot_empty = (tbl_rd.caller == 32'd0);
  assign slot_match = (tbl_rd.caller == caller_r) && (tbl_rd.callee == callee_r);

  // Sequencer: next state, table port and result registers
  always_comb begin
    state_nxt     = state_r;
    clr_nxt       = clr_r;
    caller_nxt    = caller_r;
    callee_nxt    = callee_r;
    prod_nxt      = prod_r;
    idx_nxt       = idx_r;
    probe_nxt     = probe_r;
    st_nxt        = st_r;
    slot_nxt      = slot_r;
    cnt_nxt       = cnt_r;
    drop_nxt      = drop_r;
    sat_nxt       = sat_r;
    unm_nxt       = unm_r;
    out_load      = 1'b0;
    tbl_req.wr_en   = 1'b0;
    tbl_req.addr    = idx_r;
    tbl_req.wr_data = '0;

    case (state_r)
      // Zero one slot per cycle after reset
      S_CLEAR: begin
        tbl_req.wr_en = 1'b1;
        tbl_req.addr  = clr_r;
        clr_nxt       = clr_r + idx_t'(1);
        if (clr_r == idx_t'(TABLE_DEPTH - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      // Take a word; adjust both addresses
      S_IDLE: begin
        if (in_fire) begin
          slot_nxt   = '0;
          cnt_nxt    = '0;
          caller_nxt = {in_arc.caller_return_pc[31:1], 1'b0} - 32'd2;
          callee_nxt = {in_arc.callee_return_pc[31:1], 1'b0} - 32'd2;
          if (cfg.enabled) begin
            state_nxt = S_HASH1;
          end else begin
            st_nxt    = ST_IGNORED;
            state_nxt = S_EMIT;
          end
        end
      end
      // Screen zero addresses, else first hash product
      S_HASH1: begin
        if (caller_r == 32'd0 || callee_r == 32'd0) begin
          unm_nxt   = (unm_r == CNT_MAX) ? unm_r : unm_r + 32'd1;
          st_nxt    = ST_UNMAPPED;
          state_nxt = S_EMIT;
        end else begin
          prod_nxt  = mul_lo;
          state_nxt = S_HASH2;
        end
      end
      // Second product, xor and fold give the home slot
      S_HASH2: begin
        idx_nxt   = hash_fold[IDX_W-1:0];
        probe_nxt = '0;
        state_nxt = S_READ;
      end
      S_READ: begin
        state_nxt = S_CHECK;
      end
      // Claim, bump, saturate, drop, or advance the probe
      S_CHECK: begin
        if (slot_empty) begin
          tbl_req.wr_en   = 1'b1;
          tbl_req.wr_data = '{caller: caller_r, callee: callee_r, tally: 32'd1};
          st_nxt          = ST_NEW;
          slot_nxt        = idx_r;
          cnt_nxt         = 32'd1;
          state_nxt       = S_EMIT;
        end else if (slot_match) begin
          slot_nxt  = idx_r;
          state_nxt = S_EMIT;
          if (tbl_rd.tally == CNT_MAX) begin
            sat_nxt = (sat_r == CNT_MAX) ? sat_r : sat_r + 32'd1;
            st_nxt  = ST_SATURATED;
            cnt_nxt = CNT_MAX;
          end else begin
            tbl_req.wr_en   = 1'b1;
            tbl_req.wr_data = '{caller: caller_r, callee: callee_r,
                                tally: tbl_rd.tally + 32'd1};
            st_nxt          = ST_INCREMENTED;
            cnt_nxt         = tbl_rd.tally + 32'd1;
          end
        end else if (probe_r == PRB_W'(PROBE_LIMIT - 1)) begin
          drop_nxt  = (drop_r == CNT_MAX) ? drop_r : drop_r + 32'd1;
          st_nxt    = ST_DROPPED;
          state_nxt = S_EMIT;
        end else begin
          idx_nxt   = idx_r + idx_t'(1);
          probe_nxt = probe_r + PRB_W'(1);
          state_nxt = S_READ;
        end
      end
      // Hand the result to the output register once it is free
      S_EMIT: begin
        if (!out_valid_r || out_arc.ready) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_arc.ready) begin
      out_valid_nxt = 1'b0;
    end
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end
  end

  // Control and counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      probe_r     <= '0;
      drop_r      <= '0;
      sat_r       <= '0;
      unm_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      probe_r     <= probe_nxt;
      drop_r      <= drop_nxt;
      sat_r       <= sat_nxt;
      unm_r       <= unm_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    caller_r <= caller_nxt;
    callee_r <= callee_nxt;
    prod_r   <= prod_nxt;
    idx_r    <= idx_nxt;
    st_r     <= st_nxt;
    slot_r   <= slot_nxt;
    cnt_r    <= cnt_nxt;
    if (out_load) begin
      out_st_r    <= st_r;
      out_slot_r  <= SLOT_W'(slot_r);
      out_cnt_r   <= cnt_r;
      out_drain_r <= !cfg.enabled && cfg.drain_requested;
      out_drop_r  <= drop_r;
      out_sat_r   <= sat_r;
      out_unm_r   <= unm_r;
    end
  end

  assign in_arc.ready            = (state_r == S_IDLE);
  assign out_arc.valid           = out_valid_r;
  assign out_arc.status          = out_st_r;
  assign out_arc.slot_index      = out_slot_r;
  assign out_arc.arc_count       = out_cnt_r;
  assign out_arc.drain_ready     = out_drain_r;
  assign out_arc.dropped_total   = out_drop_r;
  assign out_arc.saturated_total = out_sat_r;
  assign out_arc.unmapped_total  = out_unm_r;

  `CAHC_ASSERT_IMP(a_probe_bound, clk, rst_n, state_r == S_CHECK, probe_r < PRB_W'(PROBE_LIMIT), "probe count past limit")
  `CAHC_ASSERT_IMP(a_write_state, clk, rst_n, tbl_req.wr_en, state_r == S_CLEAR || state_r == S_CHECK, "table write outside clear or check")
  `CAHC_ASSERT_NXT(a_ignore_path, clk, rst_n, in_fire && !cfg.enabled, state_r == S_EMIT && st_r == ST_IGNORED, "disabled word not ignored")
  `CAHC_ASSERT_NXT(a_drop_mono, clk, rst_n, state_r != S_CLEAR, drop_r >= $past(drop_r), "dropped total went down")

endmodule

// File: sv/call_arc_hash_counter.sv
// A disabled word goes from accept to S_EMIT; an unmapped pair passes S_HASH1
// and S_EMIT; other pairs pass S_HASH1, S_HASH2, then S_READ and S_CHECK for
// each probe (1..16), then S_EMIT; each probe is one table read and one compare
// on the single-port table. A new word is taken only in S_IDLE, once the last
// is handed on; a result waiting in the output register does not block the
// next accept. Reset: synchronous active-low; then a pass zeroes the table,
// one slot per cycle, with in_arc.ready low (register writes are still taken).
module call_arc_hash_counter (
  input  logic                        clk,
  input  logic                        rst_n,
  arc_in_if.sink                      in_arc,
  arc_out_if.source                   out_arc,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [cahc_pkg::CFG_AW-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);
  import cahc_pkg::*;

  cfg_t     cfg;
  tbl_req_t tbl_req;
  entry_t   tbl_rd;

  cahc_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  cahc_table u_table (
    .clk     (clk),
    .req     (tbl_req),
    .rd_data (tbl_rd)
  );

  cahc_engine u_engine (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg),
    .in_arc  (in_arc),
    .out_arc (out_arc),
    .tbl_req (tbl_req),
    .tbl_rd  (tbl_rd)
  );

endmodule
